[rtl/binary_to_decimal_ascii_assert.svh]
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`ifndef SYNTHESIS
`define BDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bda assertion failed");
`define BDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bda assertion failed");
`else
`define BDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/bda_pkg.sv]
// ---------------------------------------------------------------------------
// bda_pkg
// Shared constants and types of the binary to decimal ASCII converter.
// ---------------------------------------------------------------------------
package bda_pkg;

	localparam int VALUE_W    = 64;
	localparam int NUM_DIGITS = 20;
	localparam int CHAR_W     = 6;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

	typedef struct packed {
		logic clr;
		logic dabble;
		logic unload;
	} cell_ctrl_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CONV = 4'b0010,
		S_SIGN = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

endpackage

[rtl/bda_cell.sv]
// ---------------------------------------------------------------------------
// bda_cell
// One BCD digit cell: add-3 and shift during conversion, digit shift on unload.
// ---------------------------------------------------------------------------
module bda_cell
	import bda_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       shift_in,
	input  logic [3:0] digit_in,
	output logic       carry_out,
	output logic [3:0] digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	assign adj       = (digit_q >= 4'd5) ? 4'(digit_q + 4'd3) : digit_q;
	assign carry_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			digit_q <= 4'd0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[2:0], shift_in};
		end else if (ctrl.unload) begin
			digit_q <= digit_in;
		end
	end

endmodule

[rtl/binary_to_decimal_ascii.sv]
// Sequence: the value is shifted through the digit cells after the input transfer, then a '-' sign
// when negative, then each of the 20 digit positions in turn, leading zeros skipped one per cycle.
// Input: a new value is taken only in idle, once the digits of the one before are unloaded;
// this is set by the 64-step shift through the digit cells and the 20-cell unload.
// Reset: arst_n clears the control state and any pending output; no item is held.
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii
// Double-dabble conversion of a 64-bit value in a chain of BCD digit cells,
// then digits unloaded most significant first as ASCII characters.
// ---------------------------------------------------------------------------
`include "binary_to_decimal_ascii_assert.svh"
module binary_to_decimal_ascii
	import bda_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [VALUE_W-1:0] value,
	input  logic               mode,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAR_W-1:0]  character,
	output logic               last
);

	localparam int BIT_W = $clog2(VALUE_W);
	localparam int CNT_W = $clog2(NUM_DIGITS + 1);

	state_t             state_q;
	logic [VALUE_W-1:0] mag_q;
	logic [BIT_W-1:0]   bitcnt_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic               started_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  character_q;
	logic               last_q;

	cell_ctrl_t ctrl;
	logic       carry [NUM_DIGITS+1];
	logic [3:0] digit [NUM_DIGITS];
	logic [3:0] dig_lo [NUM_DIGITS];
	logic [3:0] top_digit;

	logic in_xfer;
	logic load_ok;
	logic show;
	logic emit_load;
	logic neg_in;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign load_ok   = !out_valid_q || out_ready;
	assign top_digit = digit[NUM_DIGITS-1];
	assign show      = started_q || (top_digit != 4'd0) || (cnt_q == CNT_W'(1));
	assign emit_load = load_ok && ((state_q == S_SIGN) || ((state_q == S_EMIT) && show));
	assign neg_in    = mode && value[VALUE_W-1];

	assign ctrl.clr    = in_xfer;
	assign ctrl.dabble = (state_q == S_CONV);
	assign ctrl.unload = (state_q == S_EMIT) && (!show || load_ok);

	assign carry[0] = mag_q[VALUE_W-1];

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign dig_lo[i] = 4'd0;
		end else begin : g_rest
			assign dig_lo[i] = digit[i-1];
		end
		bda_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.shift_in  (carry[i]),
			.digit_in  (dig_lo[i]),
			.carry_out (carry[i+1]),
			.digit     (digit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bitcnt_q  <= '0;
			cnt_q     <= '0;
			neg_q     <= 1'b0;
			started_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						neg_q     <= neg_in;
						bitcnt_q  <= '0;
						started_q <= 1'b0;
						state_q   <= S_CONV;
					end
				end
				S_CONV: begin
					bitcnt_q <= BIT_W'(bitcnt_q + 1'b1);
					if (bitcnt_q == BIT_W'(VALUE_W - 1)) begin
						cnt_q   <= CNT_W'(NUM_DIGITS);
						state_q <= neg_q ? S_SIGN : S_EMIT;
					end
				end
				S_SIGN: begin
					if (load_ok) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (ctrl.unload) begin
						cnt_q <= CNT_W'(cnt_q - 1'b1);
						if (show) begin
							started_q <= 1'b1;
						end
						if (cnt_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mag_q <= neg_in ? VALUE_W'(~value + 1'b1) : value;
		end else if (state_q == S_CONV) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			if (state_q == S_SIGN) begin
				character_q <= CHAR_MINUS;
				last_q      <= 1'b0;
			end else begin
				character_q <= CHAR_W'(CHAR_ZERO + {2'b00, top_digit});
				last_q      <= (cnt_q == CNT_W'(1));
			end
		end
	end

	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;

	// top cell never overflows a 64-bit value
	`BDA_ASSERT_IMP(a_no_top_carry, clk, arst_n, ctrl.dabble, !carry[NUM_DIGITS])
	`BDA_ASSERT_IMP(a_emit_cnt, clk, arst_n, state_q == S_EMIT, cnt_q != '0)
	`BDA_ASSERT_IMP(a_sign_not_last, clk, arst_n, out_valid_q && (character_q == CHAR_MINUS), !last_q)
	`BDA_ASSERT_NXT(a_last_to_idle, clk, arst_n, emit_load && (state_q == S_EMIT) && (cnt_q == CNT_W'(1)), in_ready)

endmodule

[verif/binary_to_decimal_ascii_test.sv]
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii_test
// Feeds 64-bit values in unsigned and signed mode through the converter and
// checks every ASCII character and its last flag against the expected decimal
// text. Directed edge values come first, then random values of mixed shape,
// with random idle cycles on the input and random stalls on the output.
// ---------------------------------------------------------------------------
module binary_to_decimal_ascii_test;
	import bda_pkg::*;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               mode;
	} number_t;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              fin;
	} glyph_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [VALUE_W-1:0] value = '0;
	logic               mode = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [CHAR_W-1:0]  character;
	logic               last;

	number_t pending[$];
	glyph_t  text_due[$];
	int      faults = 0;
	int      in_gap = 0;
	bit      in_steady = 1'b0;
	int      out_hold = 0;
	bit      out_steady = 1'b0;
	glyph_t  want;

	binary_to_decimal_ascii DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.mode(mode),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.character(character),
		.last(last)
	);

	always #5 clk = ~clk;

	task automatic report(input string what);
		faults++;
		if (faults <= 10) begin
			$display("%s", what);
		end
	endtask

	task automatic queue_number(input logic [VALUE_W-1:0] v, input logic m);
		number_t n;
		n.value = v;
		n.mode = m;
		pending.push_back(n);
	endtask

	// decimal text of one number, most significant character first
	function automatic void spell_number(input logic [VALUE_W-1:0] v, input logic m);
		logic [VALUE_W-1:0] mag;
		logic [3:0]         digs[NUM_DIGITS];
		logic               neg;
		int                 n;
		glyph_t             g;
		neg = m && v[VALUE_W-1];
		mag = neg ? (~v + 64'd1) : v;
		n = 0;
		do begin
			digs[n] = 4'(mag % 64'd10);
			mag = mag / 64'd10;
			n++;
		end while (mag != 0);
		if (neg) begin
			g.ch = CHAR_MINUS;
			g.fin = 1'b0;
			text_due.push_back(g);
		end
		for (int i = n - 1; i >= 0; i--) begin
			g.ch = CHAR_ZERO + {2'b00, digs[i]};
			g.fin = (i == 0);
			text_due.push_back(g);
		end
	endfunction

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				spell_number(value, mode);
			end
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (pending.size() != 0) begin
					value <= pending[0].value;
					mode <= pending[0].mode;
					void'(pending.pop_front());
					in_valid <= 1'b1;
					if ($urandom_range(0, 15) == 0) begin
						in_steady <= ~in_steady;
					end
					in_gap <= in_steady ? 0 : $urandom_range(0, 6);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b1;
		end else if (out_valid && out_ready) begin
			if (text_due.size() == 0) begin
				report($sformatf("unexpected transfer: character %0d last %0b",
					character, last));
			end else begin
				want = text_due.pop_front();
				if (character !== want.ch) begin
					report($sformatf("character mismatch: expected %0d actual %0d",
						want.ch, character));
				end
				if (last !== want.fin) begin
					report($sformatf("last mismatch: expected %0b actual %0b",
						want.fin, last));
				end
			end
			if ($urandom_range(0, 31) == 0) begin
				out_steady <= ~out_steady;
			end
			if (out_steady) begin
				out_hold <= 0;
				out_ready <= 1'b1;
			end else begin
				out_hold <= $urandom_range(0, 6);
				out_ready <= ($urandom_range(0, 6) == 0);
			end
		end else if (!out_ready) begin
			if (out_hold <= 1) begin
				out_ready <= 1'b1;
			end else begin
				out_hold <= out_hold - 1;
			end
		end
	end

	initial begin
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] p;
		int                 k;

		// edge values
		queue_number(64'd0, 1'b0);
		queue_number(64'd0, 1'b1);
		queue_number(64'd1, 1'b0);
		queue_number(64'd9, 1'b1);
		queue_number(64'd10, 1'b0);
		queue_number(64'd99, 1'b0);
		queue_number(64'd100, 1'b1);
		queue_number('1, 1'b0);
		queue_number('1, 1'b1);
		queue_number(64'h8000_0000_0000_0000, 1'b1);
		queue_number(64'h8000_0000_0000_0000, 1'b0);
		queue_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
		queue_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		queue_number(64'd9999999999999999999, 1'b0);
		queue_number(64'd10000000000000000000, 1'b0);
		queue_number(64'd10000000000000000000, 1'b1);
		queue_number(-64'sd10, 1'b1);
		queue_number(-64'sd9, 1'b1);
		queue_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		queue_number(64'h5555_5555_5555_5555, 1'b1);

		for (int i = 0; i < 310; i++) begin
			case ($urandom_range(0, 4))
				0: v = {$urandom, $urandom};
				1: v = 64'($urandom_range(0, 1000));
				2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
				3: begin
					k = $urandom_range(0, 19);
					p = 64'd1;
					repeat (k) p = p * 64'd10;
					v = p - 64'd2 + 64'($urandom_range(0, 4));
				end
				default: v = ~64'($urandom_range(0, 1000)) + 64'd1;
			endcase
			queue_number(v, 1'($urandom_range(0, 1)));
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || in_valid) @(posedge clk);
		while (text_due.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (text_due.size() != 0) begin
			report($sformatf("%0d characters never arrived", text_due.size()));
		end
		if (faults == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#6000000;
		$display("Verification failed");
		$finish;
	end

endmodule
